@@ design/hcvc_pkg.sv @@
// Shared constants, codes and types of the half-space cut violation checker.
// Used by the interfaces and every module of the block; depends on nothing.
package hcvc_pkg;

  localparam int MAX_CUTS = 64;
  localparam int VEC_DIM  = 16;

  localparam int VAL_W     = 32;
  localparam int IDX_W     = 4;
  localparam int TYPE_W    = 2;
  localparam int HELD_W    = 7;
  localparam int ACC_W     = 64;
  localparam int FRAC_W    = 16;
  localparam int CNT_W     = $clog2(MAX_CUTS + 1);
  localparam int ROW_W     = (MAX_CUTS > 1) ? $clog2(MAX_CUTS) : 1;
  localparam int COL_W     = (VEC_DIM > 1) ? $clog2(VEC_DIM) : 1;
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int COEF_DEPTH = MAX_CUTS * VEC_DIM;

  typedef enum logic [TYPE_W-1:0] {
    REQ_COEF  = 2'd0,
    REQ_BOUND = 2'd1,
    REQ_QUERY = 2'd2
  } req_type_t;

  // Control that travels down the dot-product pipeline with each product.
  typedef struct packed {
    logic valid;
    logic first;
    logic row_end;
  } hcvc_pipe_t;

  // Signed add that clamps to the 64-bit range.
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] a,
    input logic signed [ACC_W-1:0] b
  );
    logic signed [ACC_W:0] sum;
    logic signed [ACC_W-1:0] res;
    sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      res = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      res = sum[ACC_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ design/hcvc_if.sv @@
// Valid/ready channel interfaces for request and result transfers.
// Depends on hcvc_pkg for field widths.
interface hcvc_req_if
  import hcvc_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic [TYPE_W-1:0]       req_type;
  logic [IDX_W-1:0]        elem_index;
  logic signed [VAL_W-1:0] value;
  logic                    last;

  modport source (output valid, req_type, elem_index, value, last, input ready);
  modport sink   (input valid, req_type, elem_index, value, last, output ready);
endinterface

interface hcvc_rsp_if
  import hcvc_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic              violated;
  logic [HELD_W-1:0] cuts_held;
  logic              table_overflowed;

  modport source (output valid, violated, cuts_held, table_overflowed, input ready);
  modport sink   (input valid, violated, cuts_held, table_overflowed, output ready);
endinterface

@@ design/hcvc_cut_store.sv @@
// Cut table storage: coefficient memory and bound memory, registered reads.
// Depends on hcvc_pkg.
module hcvc_cut_store
  import hcvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    coef_we,
  input  logic [ADDR_W-1:0]       coef_waddr,
  input  logic signed [VAL_W-1:0] coef_wdata,
  input  logic [ADDR_W-1:0]       coef_raddr,
  output logic signed [VAL_W-1:0] coef_rdata,
  input  logic                    bound_we,
  input  logic [ROW_W-1:0]        bound_waddr,
  input  logic signed [VAL_W-1:0] bound_wdata,
  input  logic [ROW_W-1:0]        bound_raddr,
  output logic signed [VAL_W-1:0] bound_rdata
);

  logic signed [VAL_W-1:0] coef_mem  [COEF_DEPTH];
  logic signed [VAL_W-1:0] bound_mem [MAX_CUTS];

  // Write one coefficient, read one coefficient
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    coef_rdata <= coef_mem[coef_raddr];
  end

  // Write one bound, read one bound
  always_ff @(posedge clk) begin
    if (bound_we) begin
      bound_mem[bound_waddr] <= bound_wdata;
    end
    bound_rdata <= bound_mem[bound_raddr];
  end

endmodule

@@ design/hcvc_mac.sv @@
// Shared multiply / saturating accumulate / bound compare unit.
// One product per cycle; flags a row whose sum exceeds its bound. Depends on hcvc_pkg.
module hcvc_mac
  import hcvc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  hcvc_pipe_t              ctl,
  input  logic signed [VAL_W-1:0] coef,
  input  logic signed [VAL_W-1:0] qv,
  input  logic signed [VAL_W-1:0] bound,
  output logic                    hit,
  output logic                    busy
);

  hcvc_pipe_t              ctl_mul;
  hcvc_pipe_t              ctl_acc;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [VAL_W-1:0] bound_mul;
  logic signed [VAL_W-1:0] bound_acc;
  logic signed [ACC_W-1:0] bound_ext;

  // Pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mul <= '0;
      ctl_acc <= '0;
    end else begin
      ctl_mul <= ctl;
      ctl_acc <= ctl_mul;
    end
  end

  // Multiply stage, then accumulate stage
  always_ff @(posedge clk) begin
    prod      <= ACC_W'(coef) * ACC_W'(qv);
    bound_mul <= bound;
    if (ctl_mul.valid) begin
      acc       <= ctl_mul.first ? prod : sat_add(acc, prod);
      bound_acc <= bound_mul;
    end
  end

  // Widen bound to Q48.16 and compare at row end
  assign bound_ext = {{(ACC_W-VAL_W-FRAC_W){bound_acc[VAL_W-1]}}, bound_acc, {FRAC_W{1'b0}}};
  assign hit  = ctl_acc.valid && ctl_acc.row_end && (acc > bound_ext);
  assign busy = ctl_mul.valid || ctl_acc.valid;

`ifndef NO_ASSERTIONS
  // A row always starts with a first-flagged product after the previous row end
  a_first_after_end: assert property (@(posedge clk) disable iff (rst)
    (ctl_mul.valid && ctl_mul.row_end && ctl.valid) |-> ctl.first)
    else $error("row did not restart after row end");
  // A hit only comes out of a valid row end
  a_hit_row_end: assert property (@(posedge clk) disable iff (rst)
    hit |-> $past(ctl_mul.valid && ctl_mul.row_end))
    else $error("hit without a finished row");
  // The accumulate stage takes each valid product in the cycle after the multiply stage
  a_stage_follow: assert property (@(posedge clk) disable iff (rst)
    ctl_mul.valid |=> ctl_acc.valid)
    else $error("pipeline stage lost");
`endif

endmodule

@@ design/halfspace_cut_violation_check_unit.sv @@
// Top level of the half-space cut violation checker: staging row, query vector,
// sequencer, cut store and shared dot-product unit. Depends on hcvc_pkg, hcvc_if, hcvc_cut_store, hcvc_mac.
//
//  channel | dir | fields                                   | transfer when
//  req     | in  | req_type, elem_index, value, last        | valid && ready
//  rsp     | out | violated, cuts_held, table_overflowed    | valid && ready
//
// A commit copies the staging row into the coefficient memory, one word a cycle.
// A check runs one product a cycle through the shared multiplier, and goes
// straight to the result when the table is empty.
// rst is synchronous and clears counters, flags, staging row and query vector.
// A waiting result does not stall loads; the next check's result waits for it to be taken.
module halfspace_cut_violation_check_unit
  import hcvc_pkg::*;
(
  input logic      clk,
  input logic      rst,
  hcvc_req_if.sink   req,
  hcvc_rsp_if.source rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COPY,
    S_CHECK,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        cut_count;
  logic                    overflow;
  logic [CNT_W-1:0]        row;
  logic [COL_W-1:0]        col;
  logic                    viol;
  logic signed [VAL_W-1:0] bound_hold;
  logic signed [VAL_W-1:0] staging [VEC_DIM];
  logic signed [VAL_W-1:0] query   [VEC_DIM];
  logic signed [VAL_W-1:0] q_rd;
  logic signed [VAL_W-1:0] coef_rd;
  logic signed [VAL_W-1:0] bound_rd;
  hcvc_pipe_t              ctl_rd;

  logic xfer;
  logic idx_ok;
  logic col_last;
  logic row_last;
  logic staging_clear;
  logic mac_hit;
  logic mac_busy;
  logic rsp_free;

  assign req.ready     = (state == S_IDLE);
  assign xfer          = req.valid && req.ready;
  assign idx_ok        = (32'(req.elem_index) < VEC_DIM);
  assign col_last      = (col == COL_W'(VEC_DIM - 1));
  assign row_last      = ((row + CNT_W'(1)) == cut_count);
  assign rsp_free      = !rsp.valid || rsp.ready;
  assign staging_clear = (state == S_COPY && col_last) ||
                         (xfer && req.req_type == REQ_BOUND && cut_count >= CNT_W'(MAX_CUTS));

  // Sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cut_count <= '0;
      overflow  <= 1'b0;
      row       <= '0;
      col       <= '0;
      viol      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_DONE) begin
        rsp.valid <= 1'b0;
      end
      if (mac_hit) begin
        viol <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (xfer) begin
            case (req.req_type)
              REQ_BOUND: begin
                if (cut_count < CNT_W'(MAX_CUTS)) begin
                  bound_hold <= req.value;
                  col        <= '0;
                  state      <= S_COPY;
                end else begin
                  overflow <= 1'b1;
                end
              end
              REQ_QUERY: begin
                if (req.last) begin
                  viol  <= 1'b0;
                  row   <= '0;
                  col   <= '0;
                  state <= (cut_count == '0) ? S_DONE : S_CHECK;
                end
              end
              default: ;
            endcase
          end
        end
        S_COPY: begin
          col <= col + COL_W'(1);
          if (col_last) begin
            cut_count <= cut_count + CNT_W'(1);
            state     <= S_IDLE;
          end
        end
        S_CHECK: begin
          if (col_last) begin
            col <= '0;
            row <= row + CNT_W'(1);
            if (row_last) begin
              state <= S_DRAIN;
            end
          end else begin
            col <= col + COL_W'(1);
          end
        end
        S_DRAIN: begin
          if (!ctl_rd.valid && !mac_busy) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_free) begin
            rsp.valid            <= 1'b1;
            rsp.violated         <= viol;
            rsp.cuts_held        <= HELD_W'(cut_count);
            rsp.table_overflowed <= overflow;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Staging row and query vector loads; clear staging after each commit
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VEC_DIM; i++) begin
        staging[i] <= '0;
        query[i]   <= '0;
      end
    end else if (staging_clear) begin
      for (int i = 0; i < VEC_DIM; i++) begin
        staging[i] <= '0;
      end
    end else if (xfer && idx_ok) begin
      if (req.req_type == REQ_COEF) begin
        staging[COL_W'(req.elem_index)] <= req.value;
      end else if (req.req_type == REQ_QUERY) begin
        query[COL_W'(req.elem_index)] <= req.value;
      end
    end
  end

  // Read stage control and query operand, aligned with memory read data
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_rd <= '0;
    end else begin
      ctl_rd.valid   <= (state == S_CHECK);
      ctl_rd.first   <= (col == '0);
      ctl_rd.row_end <= col_last;
    end
    q_rd <= query[col];
  end

  hcvc_cut_store u_store (
    .clk         (clk),
    .coef_we     (state == S_COPY),
    .coef_waddr  ({cut_count[ROW_W-1:0], col}),
    .coef_wdata  (staging[col]),
    .coef_raddr  ({row[ROW_W-1:0], col}),
    .coef_rdata  (coef_rd),
    .bound_we    (state == S_COPY && col_last),
    .bound_waddr (cut_count[ROW_W-1:0]),
    .bound_wdata (bound_hold),
    .bound_raddr (row[ROW_W-1:0]),
    .bound_rdata (bound_rd)
  );

  hcvc_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl_rd),
    .coef  (coef_rd),
    .qv    (q_rd),
    .bound (bound_rd),
    .hit   (mac_hit),
    .busy  (mac_busy)
  );

`ifndef NO_ASSERTIONS
  // The table never holds more cuts than it has rows
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    cut_count <= CNT_W'(MAX_CUTS))
    else $error("cut count beyond table size");
  // A finished copy adds exactly one cut
  a_commit_inc: assert property (@(posedge clk) disable iff (rst)
    (state == S_COPY && col_last) |=> cut_count == $past(cut_count) + CNT_W'(1))
    else $error("commit did not add a cut");
  // The overflow flag is sticky
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    overflow |=> overflow)
    else $error("overflow flag cleared");
  // New requests are taken only with the dot-product pipeline empty
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (!mac_busy && !ctl_rd.valid))
    else $error("request taken while check in flight");
`endif

endmodule
